>>> rtl/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and constants for the sorted priority queue cell chain.
// ============================================================================
package spq_pkg;

    localparam int KEY_W            = 32;
    localparam int OCC_W            = 5;
    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // per-cell control from the top level
    typedef struct packed {
        logic ins;       // insert that is taking place this cycle
        logic pop;       // pop that is taking place this cycle
        logic occupied;  // cell holds a live key
        logic at_tail;   // first free cell
    } cell_ctl_t;

endpackage

>>> rtl/sorted_priority_queue.sv
// ============================================================================
// sorted_priority_queue
// Min-first priority queue kept as a sorted chain of key cells.
// ============================================================================
// The queue takes one command word per clock: busy is always low, so start
// may be held high every cycle. Each accepted word gives exactly one result,
// shown on the result ports for the single cycle in which done is high, in the
// cycle after acceptance; the receiver cannot stall it and must take it then.
// The cell chain makes this possible: every cell compares its key
// with the incoming key in parallel and shifts one place toward the tail
// (insert) or the head (pop) in the same cycle. Insert places the key after
// all stored keys less than or equal to it, so equal keys leave in arrival
// order. A pop on an empty queue returns status EMPTY, an insert on a full
// queue is dropped with status FULL; occupancy is the count after the word,
// in its low five bits.
// ============================================================================
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  logic signed [KEY_W-1:0] key,
    output logic                    done,
    output logic signed [KEY_W-1:0] popped_key,
    output logic                    popped_valid,
    output logic [1:0]              status,
    output logic [OCC_W-1:0]        occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ---- fill count ---------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic accept;
    logic is_pop;
    logic full;
    logic empty;
    logic do_ins;
    logic do_pop;

    assign busy   = 1'b0;            // the queue never stalls a word
    assign accept = start && !busy;
    assign is_pop = (opcode == OP_POP);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign do_ins = accept && !is_pop && !full;
    assign do_pop = accept && is_pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        priority if (do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // ---- cell chain ---------------------------------------------------------
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic                    cell_gt  [CAPACITY];
    cell_ctl_t               cell_ctl [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic                    left_gt;
        logic signed [KEY_W-1:0] right_key;

        // head cell has nothing to its left; tail cell refills from itself
        if (i == 0)
        begin : g_head
            assign left_key = key;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_mid
            assign left_key = cell_key[i-1];
            assign left_gt  = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key = cell_key[i];
        end
        else
        begin : g_body
            assign right_key = cell_key[i+1];
        end

        assign cell_ctl[i].ins      = do_ins;
        assign cell_ctl[i].pop      = do_pop;
        assign cell_ctl[i].occupied = (CNT_W'(i) < count_reg);
        assign cell_ctl[i].at_tail  = (CNT_W'(i) == count_reg);

        spq_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[i]),
            .new_key   (key),
            .left_key  (left_key),
            .left_gt   (left_gt),
            .right_key (right_key),
            .key_out   (cell_key[i]),
            .gt_out    (cell_gt[i])
        );
    end

    // ---- result word --------------------------------------------------------
    logic                    done_reg;
    logic signed [KEY_W-1:0] popped_key_reg;
    logic signed [KEY_W-1:0] popped_key_next;
    logic                    popped_valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic [OCC_W-1:0]        occupancy_reg;

    always_comb
    begin
        status_next     = STATUS_OK;
        popped_key_next = '0;
        if (is_pop)
        begin
            if (empty)
                status_next = STATUS_EMPTY;
            else
                popped_key_next = cell_key[0];
        end
        else if (full)
        begin
            status_next = STATUS_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_key_reg   <= popped_key_next;
            popped_valid_reg <= do_pop;
            status_reg       <= status_next;
            occupancy_reg    <= OCC_W'(count_next);
        end
    end

    assign done         = done_reg;
    assign popped_key   = popped_key_reg;
    assign popped_valid = popped_valid_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;

endmodule

>>> rtl/spq_cell.sv
// ============================================================================
// spq_cell
// One slot of the sorted chain: holds a key, compares it with the incoming
// key, and shifts toward the tail on insert or toward the head on pop.
// ============================================================================
module spq_cell
    import spq_pkg::*;
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic signed [KEY_W-1:0] new_key,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic                    left_gt,
    input  logic signed [KEY_W-1:0] right_key,
    output logic signed [KEY_W-1:0] key_out,
    output logic                    gt_out
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    // stored key is strictly greater: new key lands ahead of it
    assign gt_out  = ctl.occupied && (key_reg > new_key);
    assign key_out = key_reg;

    always_comb
    begin
        key_next = key_reg;
        priority if (ctl.pop)
        begin
            key_next = right_key;
        end
        else if (ctl.ins)
        begin
            priority if (left_gt)
                key_next = left_key;
            else if (gt_out || ctl.at_tail)
                key_next = new_key;
            else
                key_next = key_reg;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

>>> rtl/spq_checker.sv
// ============================================================================
// spq_port_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ============================================================================
module spq_port_checker
    import spq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    opcode,
    input logic signed [KEY_W-1:0] key,
    input logic                    done,
    input logic signed [KEY_W-1:0] popped_key,
    input logic                    popped_valid,
    input logic [1:0]              status,
    input logic [OCC_W-1:0]        occupancy
);

    // one result per accepted word, in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted word gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without accepted word");

    // pop result kind matches the popped opcode
    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_POP) |=>
            (popped_valid && status == STATUS_OK)
            || (!popped_valid && status == STATUS_EMPTY && occupancy == '0))
        else $error("pop result inconsistent");

    // an insert never reports a popped key
    a_ins_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_INSERT) |=>
            (!popped_valid && popped_key == '0 && status != STATUS_EMPTY))
        else $error("insert result inconsistent");

endmodule

bind sorted_priority_queue spq_port_checker u_spq_checker (.*);
